// File: design/i2c_master_bit_engine_assert.svh
// ----------------------------------------------------------------------------
// I2C master bit engine assertion macros
// Clocked property checks with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define I2CM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define I2CM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2CM_ASSERT(label, clk, rst_n, prop, msg)
`define I2CM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Types, codes, reset values and helpers shared by the engine modules.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int TPU_W     = 10;
  localparam int TMO_W     = 8;
  localparam int DLY_W     = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [TPU_W-1:0] TPU_RESET = 10'd100;
  localparam logic [TMO_W-1:0] TMO_RESET = 8'd250;

  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_UNIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT    = 1'b1;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_STOP  = 3'd1,
    MODE_WRITE = 3'd2,
    MODE_WACK  = 3'd3,
    MODE_READ  = 3'd4
  } cmd_mode_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_ST_A = 5'd1,
    PH_ST_B = 5'd2,
    PH_SP_A = 5'd3,
    PH_SP_B = 5'd4,
    PH_WR_D = 5'd5,
    PH_WR_H = 5'd6,
    PH_WR_L = 5'd7,
    PH_WA_R = 5'd8,
    PH_WA_H = 5'd9,
    PH_WA_P = 5'd10,
    PH_RD_L = 5'd11,
    PH_RD_H = 5'd12,
    PH_AK_L = 5'd13,
    PH_AK_H = 5'd14
  } phase_t;

  // Delay lengths as a left shift of one unit.
  localparam logic [1:0] UNITS_1 = 2'd0;
  localparam logic [1:0] UNITS_2 = 2'd1;
  localparam logic [1:0] UNITS_4 = 2'd2;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       ack_after_read;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    phase_t           phase;
    logic [3:0]       bit_count;
    logic [7:0]       shift_reg;
    logic [DLY_W-1:0] delay_count;
    logic [TMO_W-1:0] timeout_count;
    logic             error_flag;
    logic             scl;
    logic             sda;
    logic             drv;
    logic [7:0]       rx_last;
    logic             ack_sel;
  } eng_state_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } result_t;

  localparam eng_state_t ST_RESET = '{
    phase:         PH_IDLE,
    bit_count:     4'd0,
    shift_reg:     8'd0,
    delay_count:   '0,
    timeout_count: '0,
    error_flag:    1'b0,
    scl:           1'b1,
    sda:           1'b1,
    drv:           1'b1,
    rx_last:       8'd0,
    ack_sel:       1'b0
  };

  // Last tick index of a phase lasting 1, 2 or 4 units; a zero unit acts as one tick.
  function automatic logic [DLY_W-1:0] unit_delay(input logic [1:0] sh,
                                                  input logic [TPU_W-1:0] tpu);
    logic [DLY_W-1:0] t;
    t = (tpu == '0) ? DLY_W'(1) : DLY_W'(tpu);
    return (t << sh) - DLY_W'(1);
  endfunction

endpackage

// File: design/i2cm_step.sv
// ----------------------------------------------------------------------------
// I2C master bit engine step logic
// Next engine state and result for one tick from the current state.
// ----------------------------------------------------------------------------
module i2cm_step
  import i2cm_pkg::*;
(
  input  eng_state_t       st,
  input  in_item_t         item,
  input  logic [TPU_W-1:0] tpu,
  input  logic [TMO_W-1:0] ack_timeout,
  output eng_state_t       st_nxt,
  output result_t          res
);

  logic             done;
  logic [3:0]       bc_inc;
  logic [7:0]       shl;
  logic [DLY_W-1:0] d1;
  logic [DLY_W-1:0] d2;
  logic [DLY_W-1:0] d4;

  function automatic eng_state_t enter(input eng_state_t s, input phase_t ph,
                                       input logic [DLY_W-1:0] dly, input logic scl,
                                       input logic sda, input logic drv);
    eng_state_t r;
    r             = s;
    r.phase       = ph;
    r.delay_count = dly;
    r.scl         = scl;
    r.sda         = sda;
    r.drv         = drv;
    return r;
  endfunction

  assign bc_inc = st.bit_count + 4'd1;
  assign shl    = {st.shift_reg[6:0], 1'b0};
  assign d1     = unit_delay(UNITS_1, tpu);
  assign d2     = unit_delay(UNITS_2, tpu);
  assign d4     = unit_delay(UNITS_4, tpu);

  always_comb begin
    st_nxt = st;
    done   = 1'b0;
    if (st.phase == PH_IDLE) begin
      if (item.cmd_valid) begin
        case (item.mode)
          MODE_START: st_nxt = enter(st, PH_ST_A, d4, 1'b1, 1'b1, 1'b1);
          MODE_STOP:  st_nxt = enter(st, PH_SP_A, d4, 1'b0, 1'b0, 1'b1);
          MODE_WRITE: begin
            st_nxt           = enter(st, PH_WR_D, d2, 1'b0, item.tx_byte[7], 1'b1);
            st_nxt.shift_reg = item.tx_byte;
            st_nxt.bit_count = 4'd0;
          end
          MODE_WACK:  st_nxt = enter(st, PH_WA_R, d1, st.scl, 1'b1, 1'b0);
          MODE_READ: begin
            st_nxt           = enter(st, PH_RD_L, d2, 1'b0, st.sda, 1'b0);
            st_nxt.shift_reg = 8'd0;
            st_nxt.bit_count = 4'd0;
            st_nxt.ack_sel   = item.ack_after_read;
          end
          default: st_nxt = st;
        endcase
      end
    end else if (st.phase == PH_WA_P) begin
      if (!item.sda_in) begin
        st_nxt.scl        = 1'b0;
        st_nxt.error_flag = 1'b0;
        st_nxt.phase      = PH_IDLE;
        done              = 1'b1;
      end else if (st.timeout_count >= ack_timeout) begin
        st_nxt            = enter(st, PH_SP_A, d4, 1'b0, 1'b0, 1'b1);
        st_nxt.error_flag = 1'b1;
      end else begin
        st_nxt.timeout_count = st.timeout_count + TMO_W'(1);
      end
    end else if (st.delay_count != '0) begin
      st_nxt.delay_count = st.delay_count - DLY_W'(1);
    end else begin
      case (st.phase)
        PH_ST_A: st_nxt = enter(st, PH_ST_B, d4, 1'b1, 1'b0, 1'b1);
        PH_ST_B: begin
          st_nxt.scl   = 1'b0;
          st_nxt.phase = PH_IDLE;
          done         = 1'b1;
        end
        PH_SP_A: st_nxt = enter(st, PH_SP_B, d4, 1'b1, 1'b1, 1'b1);
        PH_SP_B: begin
          st_nxt.phase = PH_IDLE;
          done         = 1'b1;
        end
        PH_WR_D: st_nxt = enter(st, PH_WR_H, d2, 1'b1, st.sda, 1'b1);
        PH_WR_H: st_nxt = enter(st, PH_WR_L, d2, 1'b0, st.sda, 1'b1);
        PH_WR_L: begin
          if (bc_inc >= BITS_PER_BYTE) begin
            st_nxt.phase = PH_IDLE;
            done         = 1'b1;
          end else begin
            st_nxt           = enter(st, PH_WR_D, d2, 1'b0, shl[7], 1'b1);
            st_nxt.shift_reg = shl;
          end
          st_nxt.bit_count = bc_inc;
        end
        PH_WA_R: st_nxt = enter(st, PH_WA_H, d1, 1'b1, 1'b1, 1'b0);
        PH_WA_H: begin
          st_nxt               = enter(st, PH_WA_P, '0, 1'b1, 1'b1, 1'b0);
          st_nxt.timeout_count = '0;
        end
        PH_RD_L: begin
          st_nxt           = enter(st, PH_RD_H, d1, 1'b1, st.sda, 1'b0);
          st_nxt.shift_reg = {st.shift_reg[6:0], item.sda_in};
        end
        PH_RD_H: begin
          if (bc_inc >= BITS_PER_BYTE) begin
            st_nxt         = enter(st, PH_AK_L, d2, 1'b0, !st.ack_sel, 1'b1);
            st_nxt.rx_last = st.shift_reg;
          end else begin
            st_nxt = enter(st, PH_RD_L, d2, 1'b0, st.sda, 1'b0);
          end
          st_nxt.bit_count = bc_inc;
        end
        PH_AK_L: st_nxt = enter(st, PH_AK_H, d2, 1'b1, st.sda, 1'b1);
        PH_AK_H: begin
          st_nxt.scl   = 1'b0;
          st_nxt.phase = PH_IDLE;
          done         = 1'b1;
        end
        default: st_nxt.phase = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    res.scl       = st_nxt.scl;
    res.sda_out   = st_nxt.sda;
    res.sda_drive = st_nxt.drv;
    res.busy_res  = (st_nxt.phase != PH_IDLE);
    res.done_res  = done;
    res.rx_byte   = st_nxt.rx_last;
    res.ack_error = st_nxt.error_flag;
  end

endmodule

// File: design/i2cm_out_reg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine result register
// Holds one finished result until the receiving side takes it.
// ----------------------------------------------------------------------------
module i2cm_out_reg
  import i2cm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  input  logic    out_stall,
  output logic    out_valid,
  output logic    slot_free,
  output result_t out_res
);

  logic    out_v_r;
  logic    out_v_nxt;
  result_t res_r;

  assign slot_free = !out_v_r || !out_stall;
  assign out_valid = out_v_r;
  assign out_res   = res_r;

  always_comb begin
    out_v_nxt = out_v_r;
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// File: design/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// I2C master bit engine
// Steps an I2C master waveform one tick per request and reports pins and status.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake        | Payload
//  in_     | input     | in_valid/stall   | cmd_valid, mode, tx_byte, ack, sda_in
//  out_    | output    | out_valid/stall  | scl, sda, drive, busy, done, rx, error
//  cfg_    | input     | cfg_valid/ready  | cfg_index, cfg_data
//
// One request is taken every cycle unless the output stalls. It waits in the
// input register; then the step logic loads its result into the result register.
// The engine state register updates once per processed request.
// Reset loads ticks_per_unit 100, ack_timeout 250 and the idle engine state.
// An output stall holds the result register and then the input register.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_assert.svh"

module i2c_master_bit_engine
  import i2cm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd_valid,
  input  logic [2:0]           in_mode,
  input  logic [7:0]           in_tx_byte,
  input  logic                 in_ack_after_read,
  input  logic                 in_sda_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_scl,
  output logic                 out_sda_out,
  output logic                 out_sda_drive,
  output logic                 out_busy_res,
  output logic                 out_done_res,
  output logic [7:0]           out_rx_byte,
  output logic                 out_ack_error,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TPU_W-1:0]     cfg_data
);

  logic             in_v_r;
  logic             in_v_nxt;
  in_item_t         item_r;
  logic             accept;
  logic             proc;
  logic             slot_free;
  eng_state_t       st_r;
  eng_state_t       st_nxt;
  result_t          res;
  result_t          out_res;
  logic [TPU_W-1:0] tpu_r;
  logic [TMO_W-1:0] tmo_r;

  assign cfg_ready = 1'b1;
  assign proc      = in_v_r && slot_free;
  assign in_stall  = in_v_r && !slot_free;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (accept) begin
      in_v_nxt = 1'b1;
    end else if (proc) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      st_r   <= ST_RESET;
      tpu_r  <= TPU_RESET;
      tmo_r  <= TMO_RESET;
    end else begin
      in_v_r <= in_v_nxt;
      if (proc) begin
        st_r <= st_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TICKS_PER_UNIT: tpu_r <= cfg_data;
          REG_ACK_TIMEOUT:    tmo_r <= cfg_data[TMO_W-1:0];
          default:            tpu_r <= tpu_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{cmd_valid:      in_cmd_valid,
                  mode:           in_mode,
                  tx_byte:        in_tx_byte,
                  ack_after_read: in_ack_after_read,
                  sda_in:         in_sda_in};
    end
  end

  i2cm_step u_step (
    .st          (st_r),
    .item        (item_r),
    .tpu         (tpu_r),
    .ack_timeout (tmo_r),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  i2cm_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (proc),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .slot_free (slot_free),
    .out_res   (out_res)
  );

  assign out_scl       = out_res.scl;
  assign out_sda_out   = out_res.sda_out;
  assign out_sda_drive = out_res.sda_drive;
  assign out_busy_res  = out_res.busy_res;
  assign out_done_res  = out_res.done_res;
  assign out_rx_byte   = out_res.rx_byte;
  assign out_ack_error = out_res.ack_error;

  property p_delay_counts_down;
    proc && st_r.delay_count != '0 && st_r.phase != PH_IDLE && st_r.phase != PH_WA_P
      |=> st_r.delay_count == $past(st_r.delay_count) - DLY_W'(1);
  endproperty

  property p_timeout_stop;
    $rose(st_r.error_flag) |-> $past(st_r.phase) == PH_WA_P && st_r.phase == PH_SP_A;
  endproperty

  `I2CM_ASSERT(a_held_item_kept, clk, rst_n, in_v_r && !proc |=> in_v_r, "held request lost")
  `I2CM_ASSERT(a_delay_counts_down, clk, rst_n, p_delay_counts_down, "delay count skipped")
  `I2CM_ASSERT(a_timeout_stop, clk, rst_n, p_timeout_stop, "timeout without stop")

endmodule

// File: tb/sv/i2c_bit_engine_checker.sv
// ----------------------------------------------------------------------------
// I2C master bit engine checker
// Watches the request, result and register channels of the bit engine, runs
// its own tick-by-tick model of the bus waveform and compares every result
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module i2c_bit_engine_checker
  import i2cm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_cmd_valid,
  input  logic [2:0]           in_mode,
  input  logic [7:0]           in_tx_byte,
  input  logic                 in_ack_after_read,
  input  logic                 in_sda_in,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_scl,
  input  logic                 out_sda_out,
  input  logic                 out_sda_drive,
  input  logic                 out_busy_res,
  input  logic                 out_done_res,
  input  logic [7:0]           out_rx_byte,
  input  logic                 out_ack_error,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TPU_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_t           eng_phase;
  logic [3:0]       eng_bits;
  logic [7:0]       eng_shift;
  logic [DLY_W-1:0] eng_delay;
  logic [TMO_W-1:0] eng_polls;
  logic             eng_err;
  logic             eng_scl;
  logic             eng_sda;
  logic             eng_drv;
  logic [7:0]       eng_rx;
  logic             eng_ack_sel;
  logic [TPU_W-1:0] reg_tpu;
  logic [TMO_W-1:0] reg_tmo;
  result_t          bus_results_q[$];
  int               result_no = 0;

  initial begin
    fail_count = 0;
    open_count = 0;
  end

  task automatic log_mismatch(input string msg);
    if (fail_count < 100) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("result %0d %s got %0h want %0h", result_no, name, got, want));
    end
  endtask

  task automatic hold_phase(input phase_t ph, input int units, input logic scl,
                            input logic sda, input logic drv);
    logic [DLY_W-1:0] unit_len;
    unit_len = (reg_tpu == '0) ? DLY_W'(1) : DLY_W'(reg_tpu);
    eng_phase = ph;
    eng_scl   = scl;
    eng_sda   = sda;
    eng_drv   = drv;
    eng_delay = (units == 0) ? '0 : DLY_W'(units * unit_len - 1);
  endtask

  task automatic next_phase(input logic sda_in, output logic done);
    done = 1'b0;
    case (eng_phase)
      PH_ST_A: hold_phase(PH_ST_B, 4, 1'b1, 1'b0, 1'b1);
      PH_ST_B: begin
        eng_scl   = 1'b0;
        eng_phase = PH_IDLE;
        done      = 1'b1;
      end
      PH_SP_A: hold_phase(PH_SP_B, 4, 1'b1, 1'b1, 1'b1);
      PH_SP_B: begin
        eng_phase = PH_IDLE;
        done      = 1'b1;
      end
      PH_WR_D: hold_phase(PH_WR_H, 2, 1'b1, eng_sda, 1'b1);
      PH_WR_H: hold_phase(PH_WR_L, 2, 1'b0, eng_sda, 1'b1);
      PH_WR_L: begin
        eng_bits = eng_bits + 4'd1;
        if (eng_bits >= BITS_PER_BYTE) begin
          eng_phase = PH_IDLE;
          done      = 1'b1;
        end else begin
          eng_shift = eng_shift << 1;
          hold_phase(PH_WR_D, 2, 1'b0, eng_shift[7], 1'b1);
        end
      end
      PH_WA_R: hold_phase(PH_WA_H, 1, 1'b1, 1'b1, 1'b0);
      PH_WA_H: begin
        hold_phase(PH_WA_P, 0, 1'b1, 1'b1, 1'b0);
        eng_polls = '0;
      end
      PH_RD_L: begin
        eng_shift = {eng_shift[6:0], sda_in};
        hold_phase(PH_RD_H, 1, 1'b1, eng_sda, 1'b0);
      end
      PH_RD_H: begin
        eng_bits = eng_bits + 4'd1;
        if (eng_bits >= BITS_PER_BYTE) begin
          eng_rx = eng_shift;
          hold_phase(PH_AK_L, 2, 1'b0, !eng_ack_sel, 1'b1);
        end else begin
          hold_phase(PH_RD_L, 2, 1'b0, eng_sda, 1'b0);
        end
      end
      PH_AK_L: hold_phase(PH_AK_H, 2, 1'b1, eng_sda, 1'b1);
      PH_AK_H: begin
        eng_scl   = 1'b0;
        eng_phase = PH_IDLE;
        done      = 1'b1;
      end
      default: eng_phase = PH_IDLE;
    endcase
  endtask

  task automatic predict_tick(input in_item_t it, output result_t r);
    logic done;
    done = 1'b0;
    if (eng_phase == PH_IDLE) begin
      if (it.cmd_valid) begin
        case (it.mode)
          MODE_START: hold_phase(PH_ST_A, 4, 1'b1, 1'b1, 1'b1);
          MODE_STOP:  hold_phase(PH_SP_A, 4, 1'b0, 1'b0, 1'b1);
          MODE_WRITE: begin
            eng_shift = it.tx_byte;
            eng_bits  = '0;
            hold_phase(PH_WR_D, 2, 1'b0, it.tx_byte[7], 1'b1);
          end
          MODE_WACK:  hold_phase(PH_WA_R, 1, eng_scl, 1'b1, 1'b0);
          MODE_READ: begin
            eng_shift   = '0;
            eng_bits    = '0;
            eng_ack_sel = it.ack_after_read;
            hold_phase(PH_RD_L, 2, 1'b0, eng_sda, 1'b0);
          end
          default: ;
        endcase
      end
    end else if (eng_phase == PH_WA_P) begin
      if (!it.sda_in) begin
        eng_scl   = 1'b0;
        eng_err   = 1'b0;
        eng_phase = PH_IDLE;
        done      = 1'b1;
      end else if (eng_polls >= reg_tmo) begin
        eng_err = 1'b1;
        hold_phase(PH_SP_A, 4, 1'b0, 1'b0, 1'b1);
      end else begin
        eng_polls = eng_polls + 1'b1;
      end
    end else if (eng_delay != '0) begin
      eng_delay = eng_delay - 1'b1;
    end else begin
      next_phase(it.sda_in, done);
    end
    r.scl       = eng_scl;
    r.sda_out   = eng_sda;
    r.sda_drive = eng_drv;
    r.busy_res  = (eng_phase != PH_IDLE);
    r.done_res  = done;
    r.rx_byte   = eng_rx;
    r.ack_error = eng_err;
  endtask

  always @(posedge clk) begin
    in_item_t req;
    result_t  want;
    if (!rst_n) begin
      eng_phase   = PH_IDLE;
      eng_bits    = '0;
      eng_shift   = '0;
      eng_delay   = '0;
      eng_polls   = '0;
      eng_err     = 1'b0;
      eng_scl     = 1'b1;
      eng_sda     = 1'b1;
      eng_drv     = 1'b1;
      eng_rx      = '0;
      eng_ack_sel = 1'b0;
      reg_tpu     = TPU_RESET;
      reg_tmo     = TMO_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TICKS_PER_UNIT: reg_tpu = cfg_data;
          REG_ACK_TIMEOUT:    reg_tmo = cfg_data[TMO_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        req.cmd_valid      = in_cmd_valid;
        req.mode           = in_mode;
        req.tx_byte        = in_tx_byte;
        req.ack_after_read = in_ack_after_read;
        req.sda_in         = in_sda_in;
        predict_tick(req, want);
        bus_results_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (bus_results_q.size() == 0) begin
          log_mismatch($sformatf("result %0d arrived with no request pending", result_no));
        end else begin
          want = bus_results_q.pop_front();
          check_field("scl", 8'(out_scl), 8'(want.scl));
          check_field("sda_out", 8'(out_sda_out), 8'(want.sda_out));
          check_field("sda_drive", 8'(out_sda_drive), 8'(want.sda_drive));
          check_field("busy", 8'(out_busy_res), 8'(want.busy_res));
          check_field("done", 8'(out_done_res), 8'(want.done_res));
          check_field("rx_byte", out_rx_byte, want.rx_byte);
          check_field("ack_error", 8'(out_ack_error), 8'(want.ack_error));
        end
        result_no++;
      end
    end
    open_count = bus_results_q.size();
  end

endmodule

// File: tb/sv/i2c_master_bit_engine_test.sv
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Feeds the engine one tick per request: directed commands first, then I2C
// transactions and stray commands with random data, SDA and ack timing, over
// several register settings, with random gaps and output stalls. A separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_test;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  localparam int          NO_ACK = 32'h3fff_ffff;
  localparam int unsigned LIMIT  = 500000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_cmd_valid = 1'b0;
  logic [2:0]           in_mode = '0;
  logic [7:0]           in_tx_byte = '0;
  logic                 in_ack_after_read = 1'b0;
  logic                 in_sda_in = 1'b1;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_scl;
  logic                 out_sda_out;
  logic                 out_sda_drive;
  logic                 out_busy_res;
  logic                 out_done_res;
  logic [7:0]           out_rx_byte;
  logic                 out_ack_error;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TPU_W-1:0]     cfg_data = '0;

  int          check_fails;
  int          check_open;
  int unsigned sent = 0;
  int unsigned recvd = 0;
  logic        last_busy = 1'b0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  int          cur_tpu = 100;
  int          cur_tmo = 250;

  i2c_master_bit_engine dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd_valid      (in_cmd_valid),
    .in_mode           (in_mode),
    .in_tx_byte        (in_tx_byte),
    .in_ack_after_read (in_ack_after_read),
    .in_sda_in         (in_sda_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_scl           (out_scl),
    .out_sda_out       (out_sda_out),
    .out_sda_drive     (out_sda_drive),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_rx_byte       (out_rx_byte),
    .out_ack_error     (out_ack_error),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  i2c_bit_engine_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd_valid      (in_cmd_valid),
    .in_mode           (in_mode),
    .in_tx_byte        (in_tx_byte),
    .in_ack_after_read (in_ack_after_read),
    .in_sda_in         (in_sda_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_scl           (out_scl),
    .out_sda_out       (out_sda_out),
    .out_sda_drive     (out_sda_drive),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_rx_byte       (out_rx_byte),
    .out_ack_error     (out_ack_error),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (check_fails),
    .open_count        (check_open)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sent <= sent + 1;
      end
      if (out_valid && !out_stall) begin
        recvd     <= recvd + 1;
        last_busy <= out_busy_res;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 19);
  end

  function automatic logic sda_for(input int ack_at, input int n);
    if (ack_at < 0) begin
      return 1'($urandom);
    end
    return (n >= ack_at) ? 1'b0 : 1'b1;
  endfunction

  function automatic int pick_ack_at();
    if ($urandom_range(3) == 0) begin
      return NO_ACK;
    end
    return $urandom_range(0, 2 * cur_tpu + cur_tmo + 4);
  endfunction

  task automatic send_tick(input logic cv, input logic [2:0] mode, input logic [7:0] tx,
                           input logic ack, input logic sda);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_cmd_valid      <= cv;
    in_mode           <= mode;
    in_tx_byte        <= tx;
    in_ack_after_read <= ack;
    in_sda_in         <= sda;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sent != recvd) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_regs(input int tpu, input int tmo);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TICKS_PER_UNIT;
    cfg_data  <= TPU_W'(tpu);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= REG_ACK_TIMEOUT;
    cfg_data  <= TPU_W'({2'($urandom_range(3)), 8'(tmo)});
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_tpu = (tpu == 0) ? 1 : tpu;
    cur_tmo = tmo;
  endtask

  // Extra commands are offered only while the engine is surely busy, so they
  // are always ignored and never start a command of their own.
  task automatic run_command(input logic [2:0] mode, input logic [7:0] tx, input logic ack,
                             input int ack_at, input int noise_pct);
    int unsigned idx;
    int          n;
    logic        cv;
    idx = sent;
    send_tick(1'b1, mode, tx, ack, sda_for(ack_at, 0));
    n = 1;
    while (!(recvd > idx && !last_busy)) begin
      cv = (mode <= MODE_READ) && (n < 2 * cur_tpu) && ($urandom_range(99) < noise_pct);
      send_tick(cv, 3'($urandom_range(7)), 8'($urandom), 1'($urandom), sda_for(ack_at, n));
      n++;
    end
  endtask

  task automatic run_transaction(input int noise_pct);
    int nbytes;
    run_command(MODE_START, 8'($urandom), 1'($urandom), -1, noise_pct);
    run_command(MODE_WRITE, 8'($urandom), 1'($urandom), -1, noise_pct);
    run_command(MODE_WACK, 8'($urandom), 1'($urandom), pick_ack_at(), noise_pct);
    nbytes = $urandom_range(1, 3);
    for (int k = 0; k < nbytes; k++) begin
      if ($urandom_range(1) == 0) begin
        run_command(MODE_WRITE, 8'($urandom), 1'($urandom), -1, noise_pct);
        run_command(MODE_WACK, 8'($urandom), 1'($urandom), pick_ack_at(), noise_pct);
      end else if ($urandom_range(4) == 0) begin
        run_command(MODE_READ, 8'($urandom), 1'($urandom), -1, noise_pct);
      end else begin
        run_command(MODE_READ, 8'($urandom), (k != nbytes - 1), -1, noise_pct);
      end
    end
    if ($urandom_range(9) != 0) begin
      run_command(MODE_STOP, 8'($urandom), 1'($urandom), -1, noise_pct);
    end
  endtask

  task automatic random_phase(input int items);
    int unsigned stop_at;
    stop_at = sent + items;
    while (sent < stop_at) begin
      if ($urandom_range(99) < 75) begin
        run_transaction(10);
      end else begin
        run_command(3'($urandom_range(7)), 8'($urandom), 1'($urandom),
                    ($urandom_range(1) == 0) ? -1 : pick_ack_at(), 10);
      end
      if ($urandom_range(7) == 0) begin
        wait_idle();
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset register values: an acknowledge wait answered after a few polls.
    run_command(MODE_WACK, 8'h00, 1'b0, 205, 0);
    wait_idle();

    program_regs(1, 3);
    run_command(MODE_START, 8'h00, 1'b0, -1, 0);
    run_command(MODE_WRITE, 8'hFF, 1'b1, -1, 0);
    run_command(MODE_WACK, 8'hFF, 1'b0, 0, 0);
    run_command(MODE_WRITE, 8'h00, 1'b0, -1, 0);
    run_command(MODE_WACK, 8'h00, 1'b0, NO_ACK, 0);
    run_command(MODE_WACK, 8'h00, 1'b1, 0, 0);
    run_command(MODE_STOP, 8'h00, 1'b0, -1, 100);
    run_command(MODE_START, 8'hFF, 1'b1, -1, 0);
    run_command(MODE_WRITE, 8'h80, 1'b0, -1, 0);
    run_command(MODE_WACK, 8'h00, 1'b0, 5, 0);
    run_command(MODE_READ, 8'h00, 1'b1, -1, 0);
    run_command(MODE_READ, 8'hFF, 1'b1, NO_ACK, 0);
    run_command(MODE_READ, 8'h00, 1'b0, 0, 0);
    run_command(MODE_WRITE, 8'h01, 1'b1, -1, 0);
    run_command(MODE_WACK, 8'h00, 1'b0, NO_ACK, 0);
    run_command(3'd5, 8'hFF, 1'b1, -1, 0);
    run_command(3'd6, 8'h00, 1'b0, -1, 0);
    run_command(3'd7, 8'hFF, 1'b1, -1, 0);
    run_command(MODE_STOP, 8'h00, 1'b0, -1, 0);
    wait_idle();

    program_regs(2, 20);
    random_phase(80);
    program_regs(0, 0);
    random_phase(100);
    calm = 1'b1;
    program_regs(1, 255);
    random_phase(80);
    calm = 1'b0;
    program_regs(3, 1);
    random_phase(60);
    program_regs(1, 1);
    random_phase(100);

    repeat (8) @(negedge clk);
    if (check_fails == 0 && check_open == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
